>>> src/pba_pkg.sv
// Shared types, constants and a helper function of the page bitmap allocator.
package pba_pkg;

  localparam int unsigned MapWordsDefault = 1024;
  localparam int unsigned WordBits        = 32;
  localparam int unsigned PageShift       = 12;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_MARK  = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] page_address;
    logic [9:0]  row_index;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] alloc_address;
    logic [31:0] row_bits;
    logic        bad_address;
  } rsp_t;

  // Index of the lowest set bit of a word; zero when the word is zero.
  function automatic logic [4:0] lowest_set(input logic [31:0] word);
    logic [4:0] idx;
    idx = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (word[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> src/pba_mem.sv
// Bitmap word memory: one write port and one read port with registered read data.
module pba_mem
  import pba_pkg::*;
#(
  parameter int unsigned MAP_WORDS = MapWordsDefault,
  parameter int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [MAP_WORDS];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/pba_ctrl.sv
// Request sequencer: clearing pass, read-modify-write and the allocate scan.
module pba_ctrl
  import pba_pkg::*;
#(
  parameter int unsigned MAP_WORDS = MapWordsDefault,
  parameter int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  req_t          req_i,
  output logic          done_o,
  output rsp_t          rsp_o,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output logic [31:0]   wdata_o,
  output logic          re_o,
  output logic [AW-1:0] raddr_o,
  input  logic [31:0]   rdata_i
);

  localparam int unsigned CW = $clog2(MAP_WORDS + 1);
  localparam logic [AW-1:0] LastWord  = AW'(MAP_WORDS - 1);
  localparam logic [CW-1:0] MapCount  = CW'(MAP_WORDS);
  localparam logic [15:0]   MapWords16 = 16'(MAP_WORDS);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_MODIFY = 4'b0100,
    ST_SCAN   = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [CW-1:0] lb_q, lb_d;
  action_e       act_q, act_d;
  logic [4:0]    bit_q, bit_d;
  logic          done_q, done_d;
  rsp_t          rsp_q, rsp_d;

  logic [14:0]   in_word;
  logic          page_bad;
  logic          row_bad;
  logic          lb_empty;
  logic [4:0]    first_bit;
  logic [31:0]   bit_mask;
  logic [31:0]   scan_mask;

  // The low-water mark lb_q is the lowest word that may hold a free page.
  assign in_word   = req_i.page_address[31:17];
  assign page_bad  = {1'b0, in_word} >= MapWords16;
  assign row_bad   = 16'(req_i.row_index) >= MapWords16;
  assign lb_empty  = (lb_q == MapCount);
  assign first_bit = lowest_set(rdata_i);
  assign bit_mask  = 32'b1 << bit_q;
  assign scan_mask = 32'b1 << first_bit;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cur_d   = cur_q;
    lb_d    = lb_q;
    act_d   = act_q;
    bit_d   = bit_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    we_o    = 1'b0;
    waddr_o = cur_q;
    wdata_o = '0;
    re_o    = 1'b0;
    raddr_o = cur_q;
    case (state_q)
      ST_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = clr_q;
        clr_d   = AW'(clr_q + 1'b1);
        if (clr_q == LastWord) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          act_d = req_i.action;
          bit_d = req_i.page_address[16:12];
          case (req_i.action)
            ACT_ALLOC: begin
              if (lb_empty) begin
                done_d = 1'b1;
                rsp_d  = '0;
              end else begin
                re_o    = 1'b1;
                raddr_o = AW'(lb_q);
                cur_d   = AW'(lb_q);
                state_d = ST_SCAN;
              end
            end
            ACT_FREE, ACT_MARK: begin
              if (page_bad) begin
                done_d            = 1'b1;
                rsp_d             = '0;
                rsp_d.bad_address = 1'b1;
              end else begin
                re_o    = 1'b1;
                raddr_o = AW'(in_word);
                cur_d   = AW'(in_word);
                state_d = ST_MODIFY;
              end
            end
            ACT_READ: begin
              if (row_bad) begin
                done_d            = 1'b1;
                rsp_d             = '0;
                rsp_d.bad_address = 1'b1;
              end else begin
                re_o    = 1'b1;
                raddr_o = AW'(req_i.row_index);
                cur_d   = AW'(req_i.row_index);
                state_d = ST_MODIFY;
              end
            end
            default: begin
              done_d = 1'b0;
            end
          endcase
        end
      end
      ST_MODIFY: begin
        done_d  = 1'b1;
        rsp_d   = '0;
        state_d = ST_IDLE;
        case (act_q)
          ACT_FREE: begin
            we_o    = 1'b1;
            wdata_o = rdata_i | bit_mask;
            if (CW'(cur_q) < lb_q) begin
              lb_d = CW'(cur_q);
            end
          end
          ACT_MARK: begin
            we_o    = 1'b1;
            wdata_o = rdata_i & ~bit_mask;
          end
          ACT_READ: begin
            rsp_d.row_bits = rdata_i;
          end
          default: begin
            we_o = 1'b0;
          end
        endcase
      end
      ST_SCAN: begin
        if (rdata_i != '0) begin
          we_o                = 1'b1;
          wdata_o             = rdata_i & ~scan_mask;
          done_d              = 1'b1;
          rsp_d               = '0;
          rsp_d.found         = 1'b1;
          rsp_d.alloc_address = 32'({cur_q, first_bit, 12'b0});
          lb_d                = CW'(cur_q);
          state_d             = ST_IDLE;
        end else if (cur_q == LastWord) begin
          done_d  = 1'b1;
          rsp_d   = '0;
          lb_d    = MapCount;
          state_d = ST_IDLE;
        end else begin
          re_o    = 1'b1;
          raddr_o = AW'(cur_q + 1'b1);
          cur_d   = AW'(cur_q + 1'b1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      lb_q    <= MapCount;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      lb_q    <= lb_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    act_q <= act_d;
    bit_q <= bit_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> src/page_bitmap_allocator_unit.sv
// Top level of the page bitmap allocator: sequencer and bitmap memory.
//
// The bitmap keeps one bit per 4 KiB page (1 = free) in MAP_WORDS words of
// 32 bits held in a synchronous memory. After reset a clearing pass writes
// every word to zero, one word per cycle, and busy stays high through the
// pass, so no word is taken before it ends. A word is taken when start is
// high and busy is low. Free, mark used and read row: the accept cycle
// issues the memory read, and the next cycle modifies and writes back the
// word, or for read row returns it. A page or row beyond the map, and an
// allocate while no page can be free, finish in the accept cycle. Allocate
// scans the words one per cycle through the single read port, starting at
// a low-water mark that tracks the lowest word that may hold a free page.
// Each result appears on rsp_o with done_o high for exactly one cycle, the
// cycle after the last cycle of its word; the receiver cannot stall it.
module page_bitmap_allocator_unit
  import pba_pkg::*;
#(
  parameter int unsigned MAP_WORDS = MapWordsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  pba_ctrl #(
    .MAP_WORDS(MAP_WORDS),
    .AW       (AW)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o),
    .we_o   (we),
    .waddr_o(waddr),
    .wdata_o(wdata),
    .re_o   (re),
    .raddr_o(raddr),
    .rdata_i(rdata)
  );

  pba_mem #(
    .MAP_WORDS(MAP_WORDS),
    .AW       (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

>>> src/pba_checker.sv
// Port-level checker of the page bitmap allocator and its bind statement.
module pba_checker
  import pba_pkg::*;
#(
  parameter int unsigned MAP_WORDS = MapWordsDefault
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  localparam logic [15:0] MapWords16 = 16'(MAP_WORDS);

  // Every accepted non-allocate word either answers at once or keeps the unit busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.action != ACT_ALLOC) |=> (done_o || busy))
    else $error("request neither answered nor in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while unit is busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.found) |->
      (rsp_o.alloc_address[11:0] == 12'd0 && !rsp_o.bad_address &&
       rsp_o.row_bits == 32'd0 &&
       {1'b0, rsp_o.alloc_address[31:17]} < MapWords16))
    else $error("allocated page address malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.found) |-> (rsp_o.alloc_address == 32'd0))
    else $error("address reported without a page taken");

endmodule

bind page_bitmap_allocator_unit pba_checker #(
  .MAP_WORDS(MAP_WORDS)
) u_pba_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .req_i (req_i),
  .done_o(done_o),
  .rsp_o (rsp_o)
);
